### sv/rgb_led_chain_pulse_encoder_unit_assert.svh
// assertion macros for the rgb led chain pulse encoder
// used by the top level; clocked on clk, disabled while arst_n is low
`ifndef RGB_LED_CHAIN_PULSE_ENCODER_UNIT_ASSERT_SVH
`define RGB_LED_CHAIN_PULSE_ENCODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// plain property check
`define RGBPE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define RGBPE_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`else

`define RGBPE_ASSERT(label, prop, msg)
`define RGBPE_ASSERT_IMPL(label, ante, cons, msg)

`endif

`endif

### sv/rgbpe_pkg.sv
// shared constants and types for the rgb led chain pulse encoder
// no dependencies
package rgbpe_pkg;

	localparam int NUM_PIXELS     = 64;
	localparam int BITS_PER_PIXEL = 24;
	localparam int PIX_W          = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
	localparam int DATA_BITS      = NUM_PIXELS * BITS_PER_PIXEL;
	// widest frame: 255 lead + data + 1023 latch bit periods
	localparam int BITPOS_W       = $clog2(255 + DATA_BITS + 1023 + 1);
	localparam int PIXEL_W        = 24;
	localparam int CFG_W          = 10;
	localparam int CFG_IDX_W      = 3;

	// bit offset into the pixel data, and the divide by three that follows the
	// divide by eight: multiply by 683 and drop 11 bits, exact below 2048
	localparam int REL_W      = $clog2(DATA_BITS);
	localparam int DIV3_MUL   = 683;
	localparam int DIV3_SHIFT = 11;
	localparam int PROD_W     = REL_W - 3 + 10;

	localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_ZERO = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_ONE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEAD      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LATCH     = 3'd4;

	localparam logic [7:0] RST_PERIOD    = 8'd59;
	localparam logic [7:0] RST_HIGH_ZERO = 8'd14;
	localparam logic [7:0] RST_HIGH_ONE  = 8'd30;
	localparam logic [7:0] RST_LEAD      = 8'd2;
	localparam logic [9:0] RST_LATCH     = 10'd64;

	localparam logic [4:0] LAST_BIT = 5'd23;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_SET    = 2'd1,
		CMD_UPDATE = 2'd2
	} cmd_t;

	// what the waveform stage needs to know about one item
	typedef struct packed {
		logic       data;
		logic       load;
		logic [4:0] bsub;
		logic [7:0] tick;
		logic       busy;
		logic       fend;
	} wave_t;

endpackage

### sv/rgbpe_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module rgbpe_ram #(
	parameter int Width = 24,
	parameter int Depth = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
	input  logic [Width-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
	output logic [Width-1:0]                       rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/rgb_led_chain_pulse_encoder_unit.sv
// top level of the rgb led chain pulse encoder
// depends on rgbpe_pkg, rgbpe_ram and rgb_led_chain_pulse_encoder_unit_assert.svh

// Takes one item per clock cycle while the output is not stalled and returns one
// result for each item: the accepting edge updates the frame counters, issues the
// pixel store read at the start of each data bit period and loads the stage
// register; the edge that moves the item on forms the line level from the read
// word and places it in the output register. While a
// result waits, one more item is taken and then the input stalls until the
// result leaves. The pixel and the bit within it are worked out from the bit
// position for every item (a shift and a reciprocal multiply), so a new lead
// length takes effect at once. The pixel store is a one-read, one-write memory;
// a pixel written by one item is seen by the read of any later item. Entries
// read as black until written (per-entry valid bits), so no clearing pass is
// needed after reset. A black frame starts straight out of reset.
`include "rgb_led_chain_pulse_encoder_unit_assert.svh"

module rgb_led_chain_pulse_encoder_unit
	import rgbpe_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  logic [1:0]           command,
	input  logic [7:0]           pixel_index,
	input  logic [7:0]           red,
	input  logic [7:0]           green,
	input  logic [7:0]           blue,
	input  logic                 wait_flag,
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic                 line_level,
	output logic                 busy_res,
	output logic                 frame_end,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// configuration
	logic [7:0] period_q, high_zero_q, high_one_q, lead_q;
	logic [9:0] latch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= RST_PERIOD;
			high_zero_q <= RST_HIGH_ZERO;
			high_one_q  <= RST_HIGH_ONE;
			lead_q      <= RST_LEAD;
			latch_q     <= RST_LATCH;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PERIOD:    period_q    <= cfg_data[7:0];
				REG_HIGH_ZERO: high_zero_q <= cfg_data[7:0];
				REG_HIGH_ONE:  high_one_q  <= cfg_data[7:0];
				REG_LEAD:      lead_q      <= cfg_data[7:0];
				REG_LATCH:     latch_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake
	logic  s1_valid_q, out_valid_q, s1_move, accept;
	wave_t wave_s1;

	assign s1_move    = s1_valid_q && (!out_valid_q || res_ready);
	assign item_ready = !s1_valid_q || s1_move;
	assign accept     = item_valid && item_ready;

	// frame state
	logic [7:0]          tick_q;
	logic [BITPOS_W-1:0] bp_q;
	logic                sending_q, changed_q, pending_q;
	logic [NUM_PIXELS-1:0] pix_vld_q;

	logic [7:0]          tick_d;
	logic [BITPOS_W-1:0] bp_d, bp_inc, total, rel;
	logic                sending_d, changed_d, pending_d;
	logic                in_data, set_ok, rd_en;
	wave_t               wave_d;

	// pixel and bit within the pixel: rel / 24 as (rel / 8) / 3
	logic [REL_W-4:0]    rel_oct;
	logic [PROD_W-1:0]   pix_prod;
	logic [PIX_W-1:0]    pix;
	logic [PIX_W+4:0]    pix_base;
	logic [4:0]          bsub;

	assign rel     = bp_q - BITPOS_W'(lead_q);
	assign in_data = (bp_q >= BITPOS_W'(lead_q)) && (rel < BITPOS_W'(DATA_BITS));
	assign bp_inc  = bp_q + 1'b1;
	assign total   = BITPOS_W'(lead_q) + BITPOS_W'(DATA_BITS) + BITPOS_W'(latch_q);
	assign set_ok  = ({1'b0, pixel_index} < 9'(NUM_PIXELS));
	assign rd_en   = accept && wave_d.load;

	assign rel_oct  = rel[REL_W-1:3];
	assign pix_prod = PROD_W'(rel_oct) * PROD_W'(DIV3_MUL);
	assign pix      = pix_prod[DIV3_SHIFT +: PIX_W];
	assign pix_base = {1'b0, pix, 4'b0000} + {2'b00, pix, 3'b000};
	assign bsub     = rel[4:0] - pix_base[4:0];

	always_comb begin
		tick_d    = tick_q;
		bp_d      = bp_q;
		sending_d = sending_q;
		changed_d = changed_q;
		pending_d = pending_q;
		wave_d    = '0;
		wave_d.tick = tick_q;
		wave_d.bsub = bsub;
		case (cmd_t'(command))
			CMD_TICK: begin
				if (sending_q) begin
					wave_d.busy = 1'b1;
					wave_d.data = in_data;
					wave_d.load = in_data && (tick_q == 8'd0);
					if (tick_q >= period_q) begin
						tick_d = '0;
						bp_d   = bp_inc;
						if (bp_inc >= total) begin
							wave_d.fend = 1'b1;
							bp_d   = '0;
							if (changed_q || pending_q) begin
								changed_d = 1'b0;
								pending_d = 1'b0;
							end else begin
								sending_d = 1'b0;
							end
						end
					end else begin
						tick_d = tick_q + 1'b1;
					end
				end
			end
			CMD_SET: begin
				if (set_ok) begin
					changed_d = 1'b1;
				end
				wave_d.busy = sending_q;
			end
			CMD_UPDATE: begin
				changed_d = 1'b0;
				if (!sending_q) begin
					sending_d = 1'b1;
					tick_d    = '0;
					bp_d      = '0;
				end else if (wait_flag) begin
					pending_d = 1'b1;
				end
				wave_d.busy = 1'b1;
			end
			default: begin
				wave_d.busy = sending_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q    <= '0;
			bp_q      <= '0;
			sending_q <= 1'b1;
			changed_q <= 1'b0;
			pending_q <= 1'b0;
			pix_vld_q <= '0;
		end else if (accept) begin
			tick_q    <= tick_d;
			bp_q      <= bp_d;
			sending_q <= sending_d;
			changed_q <= changed_d;
			pending_q <= pending_d;
			if ((cmd_t'(command) == CMD_SET) && set_ok) begin
				pix_vld_q[pixel_index[PIX_W-1:0]] <= 1'b1;
			end
		end
	end

	// pixel store
	logic [PIXEL_W-1:0] rd_word;
	logic               rd_vld_q;

	rgbpe_ram #(
		.Width(PIXEL_W),
		.Depth(NUM_PIXELS)
	) u_store (
		.clk  (clk),
		.we   (accept && (cmd_t'(command) == CMD_SET) && set_ok),
		.waddr(pixel_index[PIX_W-1:0]),
		.wdata({green, red, blue}),
		.re   (rd_en),
		.raddr(pix),
		.rdata(rd_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_q <= 1'b0;
		end else if (rd_en) begin
			rd_vld_q <= pix_vld_q[pix];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (item_ready) begin
			s1_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wave_s1 <= wave_d;
		end
	end

	// waveform stage: never-written pixels read as black
	logic [PIXEL_W-1:0] shift_q, word;
	logic               cur_bit, level;
	logic [7:0]         high;

	assign word    = wave_s1.load ? (rd_vld_q ? rd_word : '0) : shift_q;
	assign cur_bit = word[LAST_BIT - wave_s1.bsub];
	assign high    = cur_bit ? high_one_q : high_zero_q;
	assign level   = wave_s1.data && (wave_s1.tick < high);

	logic line_q, busy_q, fend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_move && wave_s1.load) begin
				shift_q <= word;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			line_q <= level;
			busy_q <= wave_s1.busy;
			fend_q <= wave_s1.fend;
		end
	end

	assign res_valid  = out_valid_q;
	assign line_level = line_q;
	assign busy_res   = busy_q;
	assign frame_end  = fend_q;

	`RGBPE_ASSERT_IMPL(a_end_busy, res_valid && frame_end, busy_res, "frame end while not busy")
	`RGBPE_ASSERT_IMPL(a_bsub_range, in_data, bsub <= LAST_BIT, "bit within pixel out of range")
	`RGBPE_ASSERT_IMPL(a_idle_clear, !sending_q, (bp_q == '0) && (tick_q == 8'd0),
		"frame counters not cleared while idle")
	`RGBPE_ASSERT_IMPL(a_stall, s1_valid_q && out_valid_q && !res_ready, !item_ready,
		"item taken while pipeline is full")
	`RGBPE_ASSERT(a_vld_sticky, 1'b1 |=> ((pix_vld_q & $past(pix_vld_q)) == $past(pix_vld_q)),
		"pixel valid bit lost")

endmodule
